/* rtl/pfa_pkg.sv */
// Shared codes and types for the page-frame allocator.
package pfa_pkg;

	localparam int WORD_BITS = 64;
	localparam int WORD_LOG  = 6;

	typedef logic [2:0] op_t;
	typedef logic [1:0] status_t;
	typedef logic [1:0] alu_mode_t;

	// operation codes
	localparam op_t OP_INIT    = 3'd0;
	localparam op_t OP_ALLOC   = 3'd1;
	localparam op_t OP_FREE    = 3'd2;
	localparam op_t OP_REF_INC = 3'd3;
	localparam op_t OP_REF_GET = 3'd4;

	// result status codes
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_MISALIGN = 2'd1;
	localparam status_t ST_RANGE    = 2'd2;
	localparam status_t ST_FULL     = 2'd3;

	// count unit modes
	localparam alu_mode_t ALU_PASS = 2'd0;
	localparam alu_mode_t ALU_INC  = 2'd1;
	localparam alu_mode_t ALU_DEC  = 2'd2;

	typedef struct packed {
		logic                found;
		logic [WORD_LOG-1:0] pos;
	} ffz_res_t;

endpackage

/* rtl/refcounted_page_frame_allocator_core.sv */
// Top level of the reference-counted first-fit page-frame allocator.
// One word in, one word out. After reset the block runs a clearing pass over
// the count RAM (and the bitmap RAM in step) and holds in_stall high
// meanwhile; cfg writes are taken at any time. Init runs the same pass,
// marking frames below the clamped reserved count used with count 1. Alloc
// streams one 64-bit bitmap word per cycle through the find-first-zero unit
// and stops at the first word that holds a free frame. Free, ref_inc and
// ref_get go through a RAM read, one pass through the shared count unit and,
// for free and ref_inc, a write-back; address errors and unknown codes go
// straight to the result stage. One word is worked on at a time; a finished
// result sits in the output register, so the next word can be accepted while
// the previous result waits.
module refcounted_page_frame_allocator_core #(
	parameter int NUM_FRAMES  = 1024,
	parameter int PAGE_SHIFT  = 12,
	parameter int COUNT_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	// config
	input  logic             cfg_wr_en,
	input  logic [10:0]      cfg_wr_data,
	// input channel
	input  logic             in_valid,
	output logic             in_stall,
	input  pfa_pkg::op_t     operation,
	input  logic [31:0]      page_address,
	// output channel
	output logic             out_valid,
	input  logic             out_stall,
	output pfa_pkg::status_t status,
	output logic [21:0]      frame_address,
	output logic [15:0]      ref_count,
	output logic [10:0]      used_frames,
	output logic [10:0]      free_frames
);
	import pfa_pkg::*;

	localparam int WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int FIW   = $clog2(NUM_FRAMES);
	localparam int TW    = $clog2(NUM_FRAMES + 1);
	localparam int CW    = COUNT_WIDTH;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SWEEP = 3'd1;
	localparam logic [2:0] S_ALLOC = 3'd2;
	localparam logic [2:0] S_C_RD  = 3'd3;
	localparam logic [2:0] S_C_EV  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]     state_q;
	logic [FIW-1:0] sweep_q;
	logic           boot_q;
	logic [TW-1:0]  held_q;
	logic [TW-1:0]  used_q;
	logic [10:0]    reserved_q;
	logic [AW-1:0]  wq;
	logic           more_q;
	logic           vld_s1;
	logic [AW-1:0]  w_s1;
	logic           out_valid_q;

	// item payload
	op_t            op_q;
	logic [31:0]    addr_q;
	logic [FIW-1:0] blk_q;
	status_t        res_status_q;
	logic [21:0]    res_faddr_q;
	logic [15:0]    res_cnt_q;
	status_t        out_status_q;
	logic [21:0]    out_faddr_q;
	logic [15:0]    out_cnt_q;
	logic [10:0]    out_used_q;
	logic [10:0]    out_free_q;

	// RAM ports
	logic                 bm_we;
	logic [AW-1:0]        bm_waddr;
	logic [WORD_BITS-1:0] bm_wdata;
	logic [AW-1:0]        bm_raddr;
	logic [WORD_BITS-1:0] bm_rdata;
	logic                 rc_we;
	logic [FIW-1:0]       rc_waddr;
	logic [CW-1:0]        rc_wdata;
	logic [CW-1:0]        rc_rdata;

	// misc datapath
	logic           acc;
	logic [31:0]    blk32;
	logic           misaligned;
	logic           bad_range;
	status_t        chk_status;
	logic [31:0]    clamp32;
	logic [31:0]    r32;
	logic [31:0]    sw_base;
	logic [31:0]    sw_diff;
	logic [WORD_BITS-1:0] sw_mask;
	logic           sweep_last;
	logic [31:0]    al_base;
	logic [31:0]    al_lim;
	logic [WORD_BITS-1:0] al_vmask;
	ffz_res_t       ffz;
	logic [31:0]    al_frame;
	logic           alloc_hit;
	logic           alloc_miss;
	alu_mode_t      alu_mode;
	logic [CW-1:0]  alu_res;
	logic           alu_a_zero;
	logic           alu_res_zero;
	logic           bit_set;
	logic           bm_clr;
	logic           load_out;

	assign in_stall = (state_q != S_IDLE);
	assign acc      = in_valid && !in_stall;

	// address checks at accept; misaligned wins over range
	assign blk32      = page_address >> PAGE_SHIFT;
	assign misaligned = (page_address & ((32'd1 << PAGE_SHIFT) - 32'd1)) != 32'd0;
	assign bad_range  = (blk32 >= 32'(NUM_FRAMES)) ||
		(operation == OP_FREE && blk32 < 32'(held_q));

	always_comb begin
		chk_status = ST_OK;
		if (operation inside {OP_FREE, OP_REF_INC, OP_REF_GET}) begin
			if (misaligned) begin
				chk_status = ST_MISALIGN;
			end else if (bad_range) begin
				chk_status = ST_RANGE;
			end
		end
	end

	assign clamp32 = (32'(reserved_q) > 32'(NUM_FRAMES)) ? 32'(NUM_FRAMES) :
		32'(reserved_q);

	// sweep: one count entry per cycle, bitmap word at each 64-frame boundary
	assign r32        = 32'(held_q);
	assign sw_base    = (32'(sweep_q) >> WORD_LOG) << WORD_LOG;
	assign sw_diff    = r32 - sw_base;
	assign sweep_last = (sweep_q == FIW'(NUM_FRAMES - 1));

	always_comb begin
		if (r32 >= sw_base + 32'(WORD_BITS)) begin
			sw_mask = '1;
		end else if (r32 <= sw_base) begin
			sw_mask = '0;
		end else begin
			sw_mask = ~({WORD_BITS{1'b1}} << sw_diff[WORD_LOG-1:0]);
		end
	end

	// alloc scan: bits past the last frame count as used
	assign al_base = 32'(w_s1) << WORD_LOG;
	assign al_lim  = 32'(NUM_FRAMES) - al_base;

	always_comb begin
		if (al_lim >= 32'(WORD_BITS)) begin
			al_vmask = '1;
		end else begin
			al_vmask = ~({WORD_BITS{1'b1}} << al_lim[WORD_LOG-1:0]);
		end
	end

	pfa_ffz u_ffz (
		.word (bm_rdata | ~al_vmask),
		.res  (ffz)
	);

	assign al_frame   = al_base | 32'(ffz.pos);
	assign alloc_hit  = (state_q == S_ALLOC) && vld_s1 && ffz.found;
	assign alloc_miss = (state_q == S_ALLOC) && vld_s1 && !ffz.found &&
		(w_s1 == AW'(WORDS - 1));

	// count update through the shared unit
	always_comb begin
		case (op_q)
			OP_REF_INC: alu_mode = ALU_INC;
			OP_FREE:    alu_mode = ALU_DEC;
			default:    alu_mode = ALU_PASS;
		endcase
	end

	pfa_cnt_alu #(.CW(CW)) u_alu (
		.mode     (alu_mode),
		.a        (rc_rdata),
		.res      (alu_res),
		.a_zero   (alu_a_zero),
		.res_zero (alu_res_zero)
	);

	assign bit_set = bm_rdata[blk_q[WORD_LOG-1:0]];
	// released only when a nonzero count drops to zero on a used frame
	assign bm_clr  = (state_q == S_C_EV) && (op_q == OP_FREE) && !alu_a_zero &&
		alu_res_zero && bit_set;

	// RAM write/read selection
	always_comb begin
		bm_we    = 1'b0;
		bm_waddr = AW'(32'(blk_q) >> WORD_LOG);
		bm_wdata = bm_rdata & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << blk_q[WORD_LOG-1:0]);
		rc_we    = 1'b0;
		rc_waddr = blk_q;
		rc_wdata = alu_res;
		case (state_q)
			S_SWEEP: begin
				rc_we    = 1'b1;
				rc_waddr = sweep_q;
				rc_wdata = CW'(32'(sweep_q) < r32);
				bm_we    = (sweep_q[WORD_LOG-1:0] == '0);
				bm_waddr = AW'(32'(sweep_q) >> WORD_LOG);
				bm_wdata = sw_mask;
			end
			S_ALLOC: begin
				rc_we    = alloc_hit;
				rc_waddr = FIW'(al_frame);
				rc_wdata = CW'(1);
				bm_we    = alloc_hit;
				bm_waddr = w_s1;
				bm_wdata = bm_rdata | ({{(WORD_BITS-1){1'b0}}, 1'b1} << ffz.pos);
			end
			S_C_EV: begin
				rc_we = (op_q != OP_REF_GET);
				bm_we = bm_clr;
			end
			default: begin
			end
		endcase
	end

	assign bm_raddr = (state_q == S_ALLOC) ? wq : AW'(32'(blk_q) >> WORD_LOG);

	pfa_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	pfa_ram #(.WIDTH(CW), .DEPTH(NUM_FRAMES)) u_refcnt (
		.clk   (clk),
		.we    (rc_we),
		.waddr (rc_waddr),
		.wdata (rc_wdata),
		.raddr (blk_q),
		.rdata (rc_rdata)
	);

	assign load_out = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_q     <= '0;
			boot_q      <= 1'b1;
			held_q      <= '0;
			used_q      <= '0;
			reserved_q  <= '0;
			wq          <= '0;
			more_q      <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				reserved_q <= cfg_wr_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (operation)
							OP_INIT: begin
								held_q  <= TW'(clamp32);
								used_q  <= TW'(clamp32);
								sweep_q <= '0;
								state_q <= S_SWEEP;
							end
							OP_ALLOC: begin
								wq      <= '0;
								more_q  <= 1'b1;
								vld_s1  <= 1'b0;
								state_q <= S_ALLOC;
							end
							OP_FREE, OP_REF_INC, OP_REF_GET: begin
								state_q <= (chk_status == ST_OK) ? S_C_RD : S_FIN;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + FIW'(1);
					if (sweep_last) begin
						boot_q  <= 1'b0;
						state_q <= boot_q ? S_IDLE : S_FIN;
					end
				end
				S_ALLOC: begin
					vld_s1 <= more_q;
					if (more_q) begin
						if (wq == AW'(WORDS - 1)) begin
							more_q <= 1'b0;
						end else begin
							wq <= wq + AW'(1);
						end
					end
					if (alloc_hit) begin
						used_q  <= used_q + TW'(1);
						state_q <= S_FIN;
					end else if (alloc_miss) begin
						state_q <= S_FIN;
					end
				end
				S_C_RD: begin
					state_q <= S_C_EV;
				end
				S_C_EV: begin
					if (bm_clr) begin
						used_q <= used_q - TW'(1);
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q         <= operation;
			addr_q       <= page_address;
			blk_q        <= FIW'(blk32);
			res_status_q <= chk_status;
			res_faddr_q  <= '0;
			res_cnt_q    <= '0;
		end
		if (state_q == S_ALLOC) begin
			w_s1 <= wq;
		end
		if (alloc_hit) begin
			res_faddr_q <= 22'(al_frame << PAGE_SHIFT);
			res_cnt_q   <= 16'd1;
		end
		if (alloc_miss) begin
			res_status_q <= ST_FULL;
		end
		if (state_q == S_C_EV) begin
			res_faddr_q <= addr_q[21:0];
			res_cnt_q   <= 16'(alu_res);
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_faddr_q  <= res_faddr_q;
			out_cnt_q    <= res_cnt_q;
			out_used_q   <= 11'(used_q);
			out_free_q   <= 11'(TW'(NUM_FRAMES) - used_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign frame_address = out_faddr_q;
	assign ref_count     = out_cnt_q;
	assign used_frames   = out_used_q;
	assign free_frames   = out_free_q;

endmodule

/* rtl/pfa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pfa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/pfa_ffz.sv */
// Find-first-zero over one bitmap word (lowest free bit).
module pfa_ffz (
	input  logic [pfa_pkg::WORD_BITS-1:0] word,
	output pfa_pkg::ffz_res_t             res
);
	import pfa_pkg::*;

	always_comb begin
		res = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				res.found = 1'b1;
				res.pos   = WORD_LOG'(i);
			end
		end
	end

endmodule

/* rtl/pfa_cnt_alu.sv */
// Shared reference-count unit: saturating increment, floored decrement, pass.
module pfa_cnt_alu #(
	parameter int CW = 16
) (
	input  pfa_pkg::alu_mode_t mode,
	input  logic [CW-1:0]      a,
	output logic [CW-1:0]      res,
	output logic               a_zero,
	output logic               res_zero
);
	import pfa_pkg::*;

	assign a_zero = (a == '0);

	always_comb begin
		case (mode)
			ALU_INC:  res = (a == {CW{1'b1}}) ? a : a + CW'(1);
			ALU_DEC:  res = a_zero ? a : a - CW'(1);
			default:  res = a;
		endcase
	end

	assign res_zero = (res == '0);

endmodule

/* rtl/pfa_checker.sv */
// Port-level checker for the page-frame allocator, bound to the top level.
module pfa_checker #(
	parameter int NUM_FRAMES = 1024
) (
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_wr_en,
	input logic [10:0]      cfg_wr_data,
	input logic             in_valid,
	input logic             in_stall,
	input pfa_pkg::op_t     operation,
	input logic [31:0]      page_address,
	input logic             out_valid,
	input logic             out_stall,
	input pfa_pkg::status_t status,
	input logic [21:0]      frame_address,
	input logic [15:0]      ref_count,
	input logic [10:0]      used_frames,
	input logic [10:0]      free_frames
);
	import pfa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(frame_address) && $stable(ref_count) && $stable(used_frames))
		else $error("stalled result word changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accept");

	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 11'(used_frames + free_frames) == 11'(NUM_FRAMES))
		else $error("used and free totals do not add up");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> frame_address == '0 && ref_count == '0)
		else $error("error result carries nonzero address or count");

endmodule

bind refcounted_page_frame_allocator_core pfa_checker #(.NUM_FRAMES(NUM_FRAMES)) u_pfa_chk (.*);
